// ----- rtl/raw_pixel_format_converter_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef RAW_PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define RAW_PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RPFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpfc assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RPFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpfc assertion failed");

`endif

// ----- rtl/rpfc_pkg.sv -----
package rpfc_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int BASE_W = 12;
  localparam int CHK_W  = 13;

  typedef enum logic [2:0] {
    REG_DISPLAY_MODE  = 3'd0,
    REG_BYTE_SWAP     = 3'd1,
    REG_FIELD_POS     = 3'd2,
    REG_FIELD_WIDTH   = 3'd3,
    REG_PAL_ENABLE    = 3'd4,
    REG_PAL_ENTRY     = 3'd5,
    REG_PAL_OFFSET    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_FIELD = 2'd1,
    MODE_565   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] display_mode;
    logic       byte_swap;
    logic [3:0] field_position;
    logic [3:0] field_width;
    logic       palette_enable;
    logic [2:0] palette_entry_size;
    logic [9:0] palette_offset;
  } cfg_t;

  localparam logic [3:0] FIELD_WIDTH_RST = 4'd8;
  localparam logic [2:0] PAL_ENTRY_RST   = 3'd3;
  localparam logic [3:0] FIELD_WIDTH_MAX = 4'd8;

endpackage

// ----- rtl/rpfc_ram.sv -----
module rpfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rpfc_regs.sv -----
module rpfc_regs
  import rpfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic     wr;
  reg_idx_t idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_mode       <= MODE_BYTE;
      cfg.byte_swap          <= 1'b0;
      cfg.field_position     <= 4'd0;
      cfg.field_width        <= FIELD_WIDTH_RST;
      cfg.palette_enable     <= 1'b0;
      cfg.palette_entry_size <= PAL_ENTRY_RST;
      cfg.palette_offset     <= 10'd0;
    end else if (wr) begin
      unique case (idx)
        REG_DISPLAY_MODE: cfg.display_mode       <= pwdata[1:0];
        REG_BYTE_SWAP:    cfg.byte_swap          <= pwdata[0];
        REG_FIELD_POS:    cfg.field_position     <= pwdata[3:0];
        REG_FIELD_WIDTH:  cfg.field_width        <= pwdata[3:0];
        REG_PAL_ENABLE:   cfg.palette_enable     <= pwdata[0];
        REG_PAL_ENTRY:    cfg.palette_entry_size <= pwdata[2:0];
        REG_PAL_OFFSET:   cfg.palette_offset     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DISPLAY_MODE: prdata = {30'd0, cfg.display_mode};
      REG_BYTE_SWAP:    prdata = {31'd0, cfg.byte_swap};
      REG_FIELD_POS:    prdata = {28'd0, cfg.field_position};
      REG_FIELD_WIDTH:  prdata = {28'd0, cfg.field_width};
      REG_PAL_ENABLE:   prdata = {31'd0, cfg.palette_enable};
      REG_PAL_ENTRY:    prdata = {29'd0, cfg.palette_entry_size};
      REG_PAL_OFFSET:   prdata = {22'd0, cfg.palette_offset};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/raw_pixel_format_converter_core.sv -----
// Convert beats pass stages v1, v2, v3 and the output register; palette writes end after v2.
// Throughput: one beat per cycle unless the output stalls; palette writes produce no result.
// The three palette bytes of a lookup come from three identical RAM copies read together.
// Reset clears the pipeline valid bits and the configuration registers.
// Palette contents are not cleared by reset and are undefined until written.
module raw_pixel_format_converter_core
  import rpfc_pkg::*;
#(
  parameter int PALETTE_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [7:0]        first_byte,
  input  logic [7:0]        second_byte,
  input  logic [9:0]        palette_address,
  input  logic [7:0]        palette_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [23:0]       packed_colour,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(PALETTE_BYTES);

  cfg_t cfg;

  rpfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  logic en1, en2, en3, en4;

  logic              v1, op1;
  logic [7:0]        b0_1, b1_1, pb_1;
  logic [9:0]        pa_1;

  logic              v2, op2;
  logic [7:0]        b0_2, rot_2, pb_2;
  logic [15:0]       word_2;
  logic [BASE_W-1:0] base_2;
  logic [9:0]        pa_2;

  logic              v3, pal_3;
  logic [2:0]        ok_3;
  logic [23:0]       direct_3;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1  <= opcode;
      b0_1 <= first_byte;
      b1_1 <= second_byte;
      pa_1 <= palette_address;
      pb_1 <= palette_byte;
    end
  end

  logic [15:0]       word_1;
  logic [31:0]       word_dbl;
  logic [BASE_W-1:0] prod_1;
  logic [BASE_W-1:0] base_1;
  logic [7:0]        rot_1;

  always_comb begin
    word_1   = cfg.byte_swap ? {b0_1, b1_1} : {b1_1, b0_1};
    word_dbl = {word_1, word_1} >> cfg.field_position;
    rot_1    = word_dbl[7:0];
    prod_1   = {4'd0, b0_1} * {9'd0, cfg.palette_entry_size};
    base_1   = prod_1 + {2'd0, cfg.palette_offset};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op2    <= op1;
      b0_2   <= b0_1;
      word_2 <= word_1;
      rot_2  <= rot_1;
      base_2 <= base_1;
      pa_2   <= pa_1;
      pb_2   <= pb_1;
    end
  end

  logic [3:0]       w2;
  logic [8:0]       mask9;
  logic [7:0]       field2, grey2;
  logic [23:0]      direct_2;
  logic             pal_2;
  logic [CHK_W-1:0] a0, a1, a2;
  logic [2:0]       ok_2;
  logic             wr_2;

  always_comb begin
    w2     = (cfg.field_width > FIELD_WIDTH_MAX) ? FIELD_WIDTH_MAX : cfg.field_width;
    mask9  = (9'd1 << w2) - 9'd1;
    field2 = rot_2 & mask9[7:0];
    grey2  = (w2 == 4'd0) ? 8'd0 : 8'(field2 << (FIELD_WIDTH_MAX - w2));
    pal_2  = (cfg.display_mode == MODE_BYTE) && cfg.palette_enable;
    case (cfg.display_mode)
      MODE_BYTE: begin
        direct_2 = {8'({6'd0, b0_2[7:6]} * 8'd85),
                    8'({5'd0, b0_2[5:3]} * 8'd36),
                    8'({5'd0, b0_2[2:0]} * 8'd36)};
      end
      MODE_FIELD: direct_2 = {16'd0, grey2};
      MODE_565: begin
        direct_2 = {word_2[4:0], 3'd0, word_2[10:5], 2'd0, word_2[15:11], 3'd0};
      end
      default: direct_2 = '0;
    endcase
    a0   = {1'b0, base_2};
    a1   = a0 + CHK_W'(1);
    a2   = a0 + CHK_W'(2);
    ok_2 = {a2 < CHK_W'(PALETTE_BYTES), a1 < CHK_W'(PALETTE_BYTES),
            a0 < CHK_W'(PALETTE_BYTES)};
    wr_2 = en3 && v2 && op2 && ({3'd0, pa_2} < CHK_W'(PALETTE_BYTES));
  end

  logic [7:0] rd0, rd1, rd2;

  rpfc_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_pal0 (
    .clk   (clk),
    .we    (wr_2),
    .waddr (AW'(pa_2)),
    .wdata (pb_2),
    .re    (en3),
    .raddr (AW'(a0)),
    .rdata (rd0)
  );

  rpfc_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_pal1 (
    .clk   (clk),
    .we    (wr_2),
    .waddr (AW'(pa_2)),
    .wdata (pb_2),
    .re    (en3),
    .raddr (AW'(a1)),
    .rdata (rd1)
  );

  rpfc_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_pal2 (
    .clk   (clk),
    .we    (wr_2),
    .waddr (AW'(pa_2)),
    .wdata (pb_2),
    .re    (en3),
    .raddr (AW'(a2)),
    .rdata (rd2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2 && !op2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pal_3    <= pal_2;
      ok_3     <= ok_2;
      direct_3 <= direct_2;
    end
  end

  logic [23:0] colour_3;

  always_comb begin
    if (pal_3) begin
      colour_3 = {ok_3[0] ? rd0 : 8'd0, ok_3[1] ? rd1 : 8'd0, ok_3[2] ? rd2 : 8'd0};
    end else begin
      colour_3 = direct_3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      packed_colour <= colour_3;
    end
  end

endmodule

// ----- rtl/rpfc_checker.sv -----
`include "raw_pixel_format_converter_core_assert.svh"

module rpfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] packed_colour
);

  // A held result beat keeps its value.
  `RPFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(packed_colour))

  // The input side only stalls when the whole pipe is full behind a stalled result.
  `RPFC_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready)

  // No result is shown right after reset.
  `RPFC_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)

  // A convert beat reaches the output when the sink does not stall along the way.
  `RPFC_ASSERT_NEXT(a_latency, (in_valid && in_ready && !opcode && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind raw_pixel_format_converter_core rpfc_checker u_rpfc_checker (.*);

// ----- dv/tb_raw_pixel_format_converter_core.sv -----
`timescale 1ns / 100ps

module tb_raw_pixel_format_converter_core;
  import rpfc_pkg::*;

  localparam int PAL_BYTES = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  class colour_ledger;
    logic [1:0] mode;
    logic swap;
    logic [3:0] pos;
    logic [3:0] width;
    logic pal_en;
    logic [2:0] entry;
    logic [9:0] offset;
    logic [7:0] palette [PAL_BYTES];
    logic [23:0] pending_colours [$];
    int errors;

    function new();
      mode = MODE_BYTE;
      swap = 1'b0;
      pos = 4'd0;
      width = FIELD_WIDTH_RST;
      pal_en = 1'b0;
      entry = PAL_ENTRY_RST;
      offset = 10'd0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_DISPLAY_MODE: mode = value[1:0];
        REG_BYTE_SWAP: swap = value[0];
        REG_FIELD_POS: pos = value[3:0];
        REG_FIELD_WIDTH: width = value[3:0];
        REG_PAL_ENABLE: pal_en = value[0];
        REG_PAL_ENTRY: entry = value[2:0];
        REG_PAL_OFFSET: offset = value[9:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pal_byte(int unsigned a);
      if (a >= PAL_BYTES) return 8'h00;
      return palette[a];
    endfunction

    function logic [23:0] expand_pixel(logic [7:0] b0, logic [7:0] b1);
      logic [15:0] word;
      logic [31:0] doubled;
      logic [31:0] field;
      logic [3:0] w;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      int unsigned base;
      word = swap ? {b0, b1} : {b1, b0};
      case (mode)
        MODE_BYTE: begin
          if (!pal_en) begin
            red = b0[2:0] * 8'd36;
            green = b0[5:3] * 8'd36;
            blue = b0[7:6] * 8'd85;
            return {blue, green, red};
          end
          base = b0 * entry + offset;
          return {pal_byte(base), pal_byte(base + 1), pal_byte(base + 2)};
        end
        MODE_FIELD: begin
          w = (width > FIELD_WIDTH_MAX) ? FIELD_WIDTH_MAX : width;
          if (w == 4'd0) return 24'h0;
          doubled = {word, word};
          field = (doubled >> pos) & ((32'd1 << w) - 32'd1);
          field = field << (8 - w);
          return {16'h0, field[7:0]};
        end
        MODE_565: return {word[4:0], 3'b000, word[10:5], 2'b00, word[15:11], 3'b000};
        default: return 24'h0;
      endcase
    endfunction

    function void note_beat(logic op, logic [7:0] b0, logic [7:0] b1, logic [9:0] addr,
                            logic [7:0] val);
      if (op == OP_PAL_WRITE) begin
        if (addr < PAL_BYTES) palette[addr] = val;
      end else begin
        pending_colours.push_back(expand_pixel(b0, b1));
      end
    endfunction

    function void match_colour(logic [23:0] got);
      logic [23:0] want;
      if (pending_colours.size() == 0) begin
        $error("packed_colour: expected none, actual %h", got);
        errors++;
        return;
      end
      want = pending_colours.pop_front();
      if (got !== want) begin
        $error("packed_colour: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_CONVERT;
  logic [7:0] first_byte = 8'h00;
  logic [7:0] second_byte = 8'h00;
  logic [9:0] palette_address = 10'd0;
  logic [7:0] palette_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] packed_colour;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  colour_ledger sb;
  bit loaded [PAL_BYTES];
  bit smooth = 1'b0;
  bit hold_req = 1'b0;
  int unsigned cycle_count = 0;

  raw_pixel_format_converter_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .first_byte(first_byte),
    .second_byte(second_byte),
    .palette_address(palette_address),
    .palette_byte(palette_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .packed_colour(packed_colour),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.match_colour(packed_colour);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!smooth) hold = pick_gap();
      end
    end
  end

  task automatic drive_beat(logic op, logic [7:0] b0, logic [7:0] b1, logic [9:0] addr,
                            logic [7:0] val);
    int gap;
    gap = smooth ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    first_byte <= b0;
    second_byte <= b1;
    palette_address <= addr;
    palette_byte <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(op, b0, b1, addr, val);
    if (op == OP_PAL_WRITE) loaded[addr] = 1'b1;
  endtask

  task automatic send_pal_write(logic [9:0] addr, logic [7:0] val);
    drive_beat(OP_PAL_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), addr, val);
  endtask

  // Any palette byte that the lookup will touch gets loaded first.
  task automatic send_pixel(logic [7:0] b0, logic [7:0] b1);
    int unsigned base;
    if (sb.mode == MODE_BYTE && sb.pal_en) begin
      base = b0 * sb.entry + sb.offset;
      for (int k = 0; k < 3; k++) begin
        if (base + k < PAL_BYTES && !loaded[base + k])
          send_pal_write(10'(base + k), 8'($urandom_range(0, 255)));
      end
    end
    drive_beat(OP_CONVERT, b0, b1, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_colours.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic program_setup(logic [1:0] m, logic s, logic [3:0] p, logic [3:0] w, logic pe,
                               logic [2:0] e, logic [9:0] o);
    settle();
    apb_write(REG_DISPLAY_MODE, 32'(m));
    apb_write(REG_BYTE_SWAP, 32'(s));
    apb_write(REG_FIELD_POS, 32'(p));
    apb_write(REG_FIELD_WIDTH, 32'(w));
    apb_write(REG_PAL_ENABLE, 32'(pe));
    apb_write(REG_PAL_ENTRY, 32'(e));
    apb_write(REG_PAL_OFFSET, 32'(o));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setup();
    logic [1:0] m;
    logic pe;
    logic [2:0] e;
    logic [3:0] w;
    logic [9:0] o;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) m = MODE_BYTE;
    else if (r < 60) m = MODE_FIELD;
    else if (r < 93) m = MODE_565;
    else m = MODE_UNUSED;
    pe = (m == MODE_BYTE) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
    e = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
    w = ($urandom_range(0, 6) != 0) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    if (r == 0) o = 10'd0;
    else if (r == 1) o = 10'd1023;
    else if (r < 6) o = 10'($urandom_range(0, 200));
    else o = 10'($urandom_range(0, 1023));
    program_setup(m, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), w, pe, e, o);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 99) < 25)
      send_pal_write(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
    else
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_pixel(8'h00, 8'h00);
    send_pixel(8'hff, 8'hff);
    send_pixel(8'h5a, 8'ha5);

    program_setup(MODE_565, 1'b0, 4'd0, FIELD_WIDTH_RST, 1'b0, PAL_ENTRY_RST, 10'd0);
    send_pixel(8'h00, 8'h00);
    send_pixel(8'hff, 8'hff);
    send_pixel(8'h00, 8'hf8);
    send_pixel(8'he0, 8'h07);
    send_pixel(8'h1f, 8'h00);
    program_setup(MODE_565, 1'b1, 4'd0, FIELD_WIDTH_RST, 1'b0, PAL_ENTRY_RST, 10'd0);
    send_pixel(8'hf8, 8'h00);
    send_pixel(8'h12, 8'h34);

    program_setup(MODE_FIELD, 1'b0, 4'd0, 4'd8, 1'b0, PAL_ENTRY_RST, 10'd0);
    send_pixel(8'ha5, 8'h3c);
    program_setup(MODE_FIELD, 1'b0, 4'd15, 4'd8, 1'b0, PAL_ENTRY_RST, 10'd0);
    send_pixel(8'h7f, 8'h80);
    send_pixel(8'h01, 8'h00);
    program_setup(MODE_FIELD, 1'b1, 4'd3, 4'd0, 1'b0, PAL_ENTRY_RST, 10'd0);
    send_pixel(8'hff, 8'hff);
    program_setup(MODE_FIELD, 1'b0, 4'd12, 4'd15, 1'b0, PAL_ENTRY_RST, 10'd0);
    send_pixel(8'hff, 8'h0f);

    program_setup(MODE_UNUSED, 1'b0, 4'd0, 4'd8, 1'b0, PAL_ENTRY_RST, 10'd0);
    send_pixel(8'hff, 8'hff);

    program_setup(MODE_BYTE, 1'b0, 4'd0, 4'd8, 1'b1, 3'd3, 10'd0);
    send_pal_write(10'd0, 8'h11);
    send_pal_write(10'd1, 8'h22);
    send_pal_write(10'd2, 8'h33);
    send_pixel(8'h00, 8'h00);
    program_setup(MODE_BYTE, 1'b0, 4'd0, 4'd8, 1'b1, 3'd4, 10'd1023);
    send_pixel(8'hff, 8'h00);
    program_setup(MODE_BYTE, 1'b0, 4'd0, 4'd8, 1'b1, 3'd0, 10'd5);
    send_pixel(8'h09, 8'h00);
    program_setup(MODE_BYTE, 1'b0, 4'd0, 4'd8, 1'b1, 3'd7, 10'd1021);
    send_pixel(8'h00, 8'h00);
    send_pixel(8'h01, 8'h00);

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 0) program_setup(MODE_BYTE, 1'b0, 4'd0, 4'd1, 1'b0, 3'd1, 10'd0);
      else if (ph == 1) program_setup(MODE_565, 1'b1, 4'd15, FIELD_WIDTH_MAX, 1'b1, 3'd4, 10'd1023);
      else if (ph == 2) program_setup(MODE_BYTE, 1'b1, 4'd15, FIELD_WIDTH_MAX, 1'b1, 3'd4, 10'd0);
      else random_setup();
      smooth = (ph % 5 == 3);
      if (ph == 6) hold_req = 1'b1;
      repeat (32) random_item();
    end

    smooth = 1'b0;
    settle();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
